// File: design/i2cseq_pkg.sv
// Shared types, constants and codes for the I2C transaction sequencer.
`timescale 1ns / 1ps

package i2cseq_pkg;

    // Queue geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int MAX_BYTES   = 16;
    localparam int QW          = $clog2(QUEUE_DEPTH);
    localparam int BW          = $clog2(MAX_BYTES);
    localparam int AW          = QW + BW;
    localparam int CW          = 5;

    // Input function codes
    localparam logic [1:0] FUNC_LOAD   = 2'd0;
    localparam logic [1:0] FUNC_COMMIT = 2'd1;
    localparam logic [1:0] FUNC_STEP   = 2'd2;

    // Engine command codes
    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_SEND  = 3'd2;
    localparam logic [2:0] CMD_RECV  = 3'd3;
    localparam logic [2:0] CMD_ACK   = 3'd4;
    localparam logic [2:0] CMD_NACK  = 3'd5;
    localparam logic [2:0] CMD_STOP  = 3'd6;

    // Commit status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_LONG = 2'd2;

    typedef struct packed {
        logic [1:0]    func;
        logic [7:0]    data_byte;
        logic [3:0]    byte_index;
        logic [6:0]    target_address;
        logic          read_flag;
        logic [CW-1:0] byte_count;
        logic          engine_done;
        logic          nack;
        logic [7:0]    rx_byte;
    } t_in;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] tx_byte;
        logic [1:0] status;
        logic       done_valid;
        logic [7:0] done_byte;
        logic       done_last;
        logic       failed;
    } t_out;

    // Transaction descriptor kept per queue slot
    typedef struct packed {
        logic [6:0]    addr;
        logic          rd;
        logic [CW-1:0] cnt;
    } t_desc;

    typedef struct packed {
        logic          bwe;
        logic [AW-1:0] bwaddr;
        logic [7:0]    bwdata;
        logic [AW-1:0] braddr;
        logic          dwe;
        logic [QW-1:0] dwaddr;
        t_desc         dwdata;
        logic [QW-1:0] draddr;
    } t_mem_req;

    typedef struct packed {
        logic [7:0] brdata;
        t_desc      drdata;
    } t_mem_rsp;

    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_START      = 4'd1,
        PH_ADDR       = 4'd2,
        PH_ADDR_ACK   = 4'd3,
        PH_TX         = 4'd4,
        PH_RX         = 4'd5,
        PH_TX_ACK     = 4'd6,
        PH_RX_ACK     = 4'd7,
        PH_RX_ACKWAIT = 4'd8,
        PH_STOP       = 4'd9,
        PH_STOP_WAIT  = 4'd10,
        PH_RETRY      = 4'd11,
        PH_FAIL       = 4'd12
    } t_phase;

    typedef enum logic [1:0] {
        CT_IDLE   = 2'd0,
        CT_EXEC   = 2'd1,
        CT_STREAM = 2'd2
    } t_ctrl;

endpackage

// File: design/i2cseq_store.sv
// Byte buffer memory and descriptor memory, both with registered read data.
`timescale 1ns / 1ps

module i2cseq_store import i2cseq_pkg::*; (
    input  logic     i_clk,
    input  t_mem_req i_req,
    output t_mem_rsp o_rsp
);

    logic [7:0] r_bytes [QUEUE_DEPTH*MAX_BYTES];
    t_desc      r_descs [QUEUE_DEPTH];
    logic [7:0] r_brdata;
    t_desc      r_drdata;

    // byte buffer: one write port, one read port
    always_ff @(posedge i_clk) begin
        if (i_req.bwe) begin
            r_bytes[i_req.bwaddr] <= i_req.bwdata;
        end
        r_brdata <= r_bytes[i_req.braddr];
    end

    // descriptor ring
    always_ff @(posedge i_clk) begin
        if (i_req.dwe) begin
            r_descs[i_req.dwaddr] <= i_req.dwdata;
        end
        r_drdata <= r_descs[i_req.draddr];
    end

    assign o_rsp.brdata = r_brdata;
    assign o_rsp.drdata = r_drdata;

endmodule

// File: design/i2cseq_ctrl.sv
// Sequencer control: queue pointers, bus phase machine and result register.
`timescale 1ns / 1ps

module i2cseq_ctrl import i2cseq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  t_in        i_word,
    output logic       o_valid,
    input  logic       i_stall,
    output t_out       o_word,
    input  logic [7:0] i_retry_limit,
    output t_mem_req   o_req,
    input  t_mem_rsp   i_rsp
);

    t_ctrl         r_ctrl,    n_ctrl;
    t_phase        r_phase,   n_phase;
    logic [7:0]    r_retry,   n_retry;
    logic [QW-1:0] r_head,    n_head;
    logic [QW-1:0] r_tail,    n_tail;
    logic          r_eflag,   n_eflag;
    logic [CW-1:0] r_pos,     n_pos;
    t_in           r_in,      n_in;
    logic [BW-1:0] r_k,       n_k;
    logic [CW-1:0] r_n,       n_n;
    logic          r_rd_ok,   n_rd_ok;
    t_out          r_out,     n_out;
    logic          r_out_valid, n_out_valid;

    logic          w_ef;
    logic          w_out_free;
    logic          w_full;
    logic          w_long;
    logic [QW-1:0] w_queued;

    // shared conditions
    assign w_ef       = r_eflag | r_in.engine_done;
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_queued   = r_tail - r_head;
    assign w_full     = (w_queued >= QW'(QUEUE_DEPTH - 1));
    assign w_long     = (r_in.byte_count > CW'(MAX_BYTES));

    // next state
    always_comb begin : next_state
        logic          emit;
        logic          last;
        t_out          res;
        logic [CW-1:0] pos_inc;
        logic [CW-1:0] n_bytes;
        t_desc         d;

        n_ctrl      = r_ctrl;
        n_phase     = r_phase;
        n_retry     = r_retry;
        n_head      = r_head;
        n_tail      = r_tail;
        n_eflag     = r_eflag;
        n_pos       = r_pos;
        n_in        = r_in;
        n_k         = r_k;
        n_n         = r_n;
        n_rd_ok     = r_rd_ok;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_stall;

        emit    = 1'b0;
        last    = 1'b0;
        res     = '0;
        d       = i_rsp.drdata;
        pos_inc = r_pos + CW'(1);
        n_bytes = (d.cnt > CW'(MAX_BYTES)) ? CW'(MAX_BYTES) : d.cnt;

        case (r_ctrl)
            CT_IDLE: begin
                if (i_valid) begin
                    n_in   = i_word;
                    n_ctrl = CT_EXEC;
                end
            end

            CT_EXEC: begin
                n_ctrl = CT_IDLE;
                case (r_in.func)
                    FUNC_COMMIT: begin
                        emit = 1'b1;
                        if (w_full) begin
                            res.status = ST_FULL;
                        end else if (w_long) begin
                            res.status = ST_LONG;
                        end else begin
                            res.status = ST_OK;
                            n_tail     = r_tail + QW'(1);
                        end
                    end

                    FUNC_STEP: begin
                        n_eflag = w_ef;
                        case (r_phase)
                            PH_START: begin
                                emit        = 1'b1;
                                res.command = CMD_START;
                                n_phase     = PH_ADDR;
                            end
                            PH_ADDR: begin
                                if (w_ef) begin
                                    n_eflag     = 1'b0;
                                    emit        = 1'b1;
                                    res.command = CMD_SEND;
                                    res.tx_byte = {d.addr, d.rd};
                                    n_phase     = PH_ADDR_ACK;
                                end
                            end
                            PH_ADDR_ACK, PH_TX_ACK: begin
                                if (w_ef) begin
                                    n_eflag = 1'b0;
                                    if (r_in.nack) begin
                                        if (r_retry >= i_retry_limit) begin
                                            n_retry = '0;
                                            n_phase = PH_FAIL;
                                        end else begin
                                            n_retry = r_retry + 8'd1;
                                            n_phase = PH_RETRY;
                                        end
                                    end else begin
                                        n_retry = '0;
                                        if (r_phase == PH_TX_ACK) begin
                                            n_pos   = pos_inc;
                                            n_phase = (pos_inc >= d.cnt) ? PH_STOP : PH_TX;
                                        end else if (d.rd) begin
                                            emit        = 1'b1;
                                            res.command = CMD_RECV;
                                            n_phase     = PH_RX;
                                        end else begin
                                            n_phase = PH_TX;
                                        end
                                    end
                                end
                            end
                            PH_RX: begin
                                // received byte is written by the memory request
                                if (w_ef) begin
                                    n_eflag = 1'b0;
                                    n_phase = PH_RX_ACK;
                                end
                            end
                            PH_RX_ACK: begin
                                emit        = 1'b1;
                                res.command = (pos_inc >= d.cnt) ? CMD_NACK : CMD_ACK;
                                n_pos       = pos_inc;
                                n_phase     = PH_RX_ACKWAIT;
                            end
                            PH_RX_ACKWAIT: begin
                                if (w_ef) begin
                                    n_eflag = 1'b0;
                                    if (r_pos >= d.cnt) begin
                                        n_phase = PH_STOP;
                                    end else begin
                                        emit        = 1'b1;
                                        res.command = CMD_RECV;
                                        n_phase     = PH_RX;
                                    end
                                end
                            end
                            PH_TX: begin
                                emit        = 1'b1;
                                res.command = CMD_SEND;
                                res.tx_byte = (r_pos < CW'(MAX_BYTES)) ? i_rsp.brdata : 8'd0;
                                n_phase     = PH_TX_ACK;
                            end
                            PH_STOP: begin
                                if (n_bytes == '0) begin
                                    emit          = 1'b1;
                                    res.command   = CMD_STOP;
                                    res.done_last = 1'b1;
                                    n_head        = r_head + QW'(1);
                                    n_pos         = '0;
                                    n_phase       = PH_STOP_WAIT;
                                end else begin
                                    // completion bytes go out one by one
                                    n_n     = n_bytes;
                                    n_k     = '0;
                                    n_rd_ok = 1'b0;
                                    n_ctrl  = CT_STREAM;
                                end
                            end
                            PH_STOP_WAIT: begin
                                if (w_ef) begin
                                    n_eflag = 1'b0;
                                    n_phase = PH_IDLE;
                                end
                            end
                            PH_RETRY: begin
                                n_phase = PH_START;
                            end
                            PH_FAIL: begin
                                emit          = 1'b1;
                                res.done_last = 1'b1;
                                res.failed    = 1'b1;
                                n_head        = r_head + QW'(1);
                                n_pos         = '0;
                                n_retry       = '0;
                                n_phase       = PH_IDLE;
                            end
                            default: begin
                                n_phase = (w_queued != '0) ? PH_START : PH_IDLE;
                            end
                        endcase
                    end

                    default: begin
                        // loads are written by the memory request; code 3 is a no-op
                    end
                endcase

                // result register busy: hold everything and retry next cycle
                if (emit) begin
                    if (w_out_free) begin
                        n_out       = res;
                        n_out_valid = 1'b1;
                    end else begin
                        n_ctrl  = CT_EXEC;
                        n_phase = r_phase;
                        n_retry = r_retry;
                        n_head  = r_head;
                        n_tail  = r_tail;
                        n_eflag = r_eflag;
                        n_pos   = r_pos;
                    end
                end
            end

            CT_STREAM: begin
                if (!r_rd_ok) begin
                    n_rd_ok = 1'b1;
                end else if (w_out_free) begin
                    last           = ((CW'(r_k) + CW'(1)) == r_n);
                    res.command    = (r_k == '0) ? CMD_STOP : CMD_NONE;
                    res.done_valid = 1'b1;
                    res.done_byte  = i_rsp.brdata;
                    res.done_last  = last;
                    n_out          = res;
                    n_out_valid    = 1'b1;
                    n_k            = r_k + BW'(1);
                    n_rd_ok        = 1'b0;
                    if (last) begin
                        n_head  = r_head + QW'(1);
                        n_pos   = '0;
                        n_phase = PH_STOP_WAIT;
                        n_ctrl  = CT_IDLE;
                    end
                end
            end

            default: begin
                n_ctrl = CT_IDLE;
            end
        endcase
    end

    // outputs and memory requests
    always_comb begin : outputs
        o_stall = (r_ctrl != CT_IDLE);
        o_valid = r_out_valid;
        o_word  = r_out;

        o_req        = '0;
        o_req.draddr = r_head;
        o_req.braddr = (r_ctrl == CT_STREAM) ? {r_head, r_k} : {r_head, r_pos[BW-1:0]};

        if (r_ctrl == CT_EXEC) begin
            if (r_in.func == FUNC_LOAD && {1'b0, r_in.byte_index} < 5'(MAX_BYTES)) begin
                o_req.bwe    = 1'b1;
                o_req.bwaddr = {r_tail, r_in.byte_index[BW-1:0]};
                o_req.bwdata = r_in.data_byte;
            end else if (r_in.func == FUNC_STEP && r_phase == PH_RX && w_ef
                         && r_pos < CW'(MAX_BYTES)) begin
                o_req.bwe    = 1'b1;
                o_req.bwaddr = {r_head, r_pos[BW-1:0]};
                o_req.bwdata = r_in.rx_byte;
            end

            if (r_in.func == FUNC_COMMIT && !w_full && !w_long && w_out_free) begin
                o_req.dwe         = 1'b1;
                o_req.dwaddr      = r_tail;
                o_req.dwdata.addr = r_in.target_address;
                o_req.dwdata.rd   = r_in.read_flag;
                o_req.dwdata.cnt  = r_in.byte_count;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl      <= CT_IDLE;
            r_phase     <= PH_IDLE;
            r_retry     <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_eflag     <= 1'b0;
            r_pos       <= '0;
            r_rd_ok     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_ctrl      <= n_ctrl;
            r_phase     <= n_phase;
            r_retry     <= n_retry;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_eflag     <= n_eflag;
            r_pos       <= n_pos;
            r_rd_ok     <= n_rd_ok;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_in  <= n_in;
        r_k   <= n_k;
        r_n   <= n_n;
        r_out <= n_out;
    end

endmodule

// File: design/i2c_master_transaction_sequencer.sv
// Top level: APB register for the retry limit, control and storage.
// A word is accepted while the control is idle and worked in the next cycle; its result,
// if any, is written to the result register and from there shows on o_valid.
// A new word is taken only while idle (o_stall low); a result that finds the result register
// busy holds the block until it drains, and a completion run reads the buffer once per stored byte.
// Reset (i_rst_n low, synchronous): queue empty, phase idle, retry limit 16;
// buffer and descriptor memories keep their contents and are not cleared.
`timescale 1ns / 1ps

module i2c_master_transaction_sequencer import i2cseq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in         i_word,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out        o_word,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic       REG_RETRY_LIMIT   = 1'b0;
    localparam logic [7:0] RETRY_LIMIT_RESET = 8'd16;

    logic [7:0] r_retry_limit;
    t_mem_req   w_req;
    t_mem_rsp   w_rsp;

    // register port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_RETRY_LIMIT) ? {24'd0, r_retry_limit} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retry_limit <= RETRY_LIMIT_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_RETRY_LIMIT) begin
            r_retry_limit <= pwdata[7:0];
        end
    end

    i2cseq_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_word        (i_word),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_word        (o_word),
        .i_retry_limit (r_retry_limit),
        .o_req         (w_req),
        .i_rsp         (w_rsp)
    );

    i2cseq_store u_store (
        .i_clk (i_clk),
        .i_req (w_req),
        .o_rsp (w_rsp)
    );

endmodule

// File: design/i2cseq_checker.sv
// Port-level checks for the sequencer, bound to the top level.
`timescale 1ns / 1ps

module i2cseq_checker import i2cseq_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_valid,
    input logic i_stall,
    input t_out o_word
);

    // a stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_word))
        else $error("result word changed under stall");

    // no result word survives reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // a failure word is last, with no completion byte and no bus command
    a_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_word.failed |->
            o_word.done_last && !o_word.done_valid && o_word.command == CMD_NONE)
        else $error("malformed failure word");

    // commit status is never mixed with bus or completion content
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_word.status != ST_OK |->
            o_word.command == CMD_NONE && !o_word.done_valid && !o_word.done_last)
        else $error("status word carries other content");

    // completion bytes come with a stop or no command, never with a bus byte
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_word.done_valid |->
            (o_word.command == CMD_STOP || o_word.command == CMD_NONE)
            && o_word.tx_byte == 8'd0)
        else $error("completion word carries a bus command");

endmodule

bind i2c_master_transaction_sequencer i2cseq_checker u_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_word  (o_word)
);

// File: verif/testbench.sv
// Self-checking testbench for the I2C master transaction sequencer.
`timescale 1ns / 1ps

module testbench;
    import i2cseq_pkg::*;

    // Unused function code; the block must ignore it
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    // APB byte address of the retry limit register
    localparam logic [2:0] ADDR_RETRY_LIMIT = 3'd0;
    localparam int WATCHDOG_CYCLES = 2000;
    localparam int SETTLE_CYCLES = 4;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    t_in         i_word = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    t_out        o_word;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    i2c_master_transaction_sequencer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_word  (i_word),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_word  (o_word),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Words waiting to be sent and results the predictor expects
    t_in  stim_words[$];
    t_out predicted_results[$];

    int n_queued = 0;
    int n_accepted = 0;
    int n_results = 0;
    int n_errors = 0;
    int n_completions = 0;
    int n_failures = 0;
    int n_retries = 0;
    int n_full = 0;
    int n_long = 0;
    int send_gap = 0;
    int stall_left = 0;
    int hold_left = 0;
    int idle_cycles = 0;
    bit quiet = 1'b0;

    // Sequencer shadow state
    t_phase     ph = PH_IDLE;
    logic [7:0] retries = '0;
    logic [7:0] retry_lim = 8'd16;
    int         head_idx = 0;
    int         tail_idx = 0;
    logic       engine_pending = 1'b0;
    logic [4:0] pos = '0;
    logic [7:0] bytes_mem [QUEUE_DEPTH*MAX_BYTES];
    logic [6:0] addr_mem [QUEUE_DEPTH];
    logic       rd_mem [QUEUE_DEPTH];
    logic [4:0] cnt_mem [QUEUE_DEPTH];

    function automatic void emit_result(logic [2:0] cmd, logic [7:0] tx, logic [1:0] st,
                                        logic dv, logic [7:0] db, logic dl, logic fl);
        t_out r;
        r.command = cmd;
        r.tx_byte = tx;
        r.status = st;
        r.done_valid = dv;
        r.done_byte = db;
        r.done_last = dl;
        r.failed = fl;
        predicted_results.push_back(r);
    endfunction

    function automatic logic [7:0] buf_byte(int slot, int p);
        return (p >= MAX_BYTES) ? 8'd0 : bytes_mem[slot*MAX_BYTES + p];
    endfunction

    // Consume a latched engine-done flag
    function automatic bit take_engine();
        if (!engine_pending) return 1'b0;
        engine_pending = 1'b0;
        return 1'b1;
    endfunction

    // NACK: retry from start, or give up once the limit is used
    function automatic void nack_seen();
        if (retries >= retry_lim) begin
            retries = '0;
            ph = PH_FAIL;
        end else begin
            retries = retries + 8'd1;
            ph = PH_RETRY;
            n_retries++;
        end
    endfunction

    function automatic void step_sequencer(t_in w);
        int h;
        int n;
        logic [4:0] c;
        h = head_idx;
        c = cnt_mem[h];
        if (w.engine_done) engine_pending = 1'b1;
        case (ph)
            PH_START: begin
                ph = PH_ADDR;
                emit_result(CMD_START, 8'd0, ST_OK, 1'b0, 8'd0, 1'b0, 1'b0);
            end
            PH_ADDR: begin
                if (take_engine()) begin
                    ph = PH_ADDR_ACK;
                    emit_result(CMD_SEND, {addr_mem[h], rd_mem[h]}, ST_OK,
                                1'b0, 8'd0, 1'b0, 1'b0);
                end
            end
            PH_ADDR_ACK: begin
                if (take_engine()) begin
                    if (w.nack) begin
                        nack_seen();
                    end else begin
                        retries = '0;
                        if (rd_mem[h]) begin
                            ph = PH_RX;
                            emit_result(CMD_RECV, 8'd0, ST_OK, 1'b0, 8'd0, 1'b0, 1'b0);
                        end else begin
                            ph = PH_TX;
                        end
                    end
                end
            end
            PH_RX: begin
                if (take_engine()) begin
                    if (pos < MAX_BYTES) bytes_mem[h*MAX_BYTES + pos] = w.rx_byte;
                    ph = PH_RX_ACK;
                end
            end
            PH_RX_ACK: begin
                pos = pos + 5'd1;
                ph = PH_RX_ACKWAIT;
                emit_result((pos >= c) ? CMD_NACK : CMD_ACK, 8'd0, ST_OK,
                            1'b0, 8'd0, 1'b0, 1'b0);
            end
            PH_RX_ACKWAIT: begin
                if (take_engine()) begin
                    if (pos >= c) begin
                        ph = PH_STOP;
                    end else begin
                        ph = PH_RX;
                        emit_result(CMD_RECV, 8'd0, ST_OK, 1'b0, 8'd0, 1'b0, 1'b0);
                    end
                end
            end
            PH_TX: begin
                ph = PH_TX_ACK;
                emit_result(CMD_SEND, buf_byte(h, pos), ST_OK, 1'b0, 8'd0, 1'b0, 1'b0);
            end
            PH_TX_ACK: begin
                if (take_engine()) begin
                    if (w.nack) begin
                        nack_seen();
                    end else begin
                        retries = '0;
                        pos = pos + 5'd1;
                        ph = (pos >= c) ? PH_STOP : PH_TX;
                    end
                end
            end
            PH_STOP: begin
                // Completion run: stop on the first word, one word per stored byte (a lone stop word if none)
                n = (c > MAX_BYTES) ? MAX_BYTES : c;
                if (n == 0) begin
                    emit_result(CMD_STOP, 8'd0, ST_OK, 1'b0, 8'd0, 1'b1, 1'b0);
                end else begin
                    for (int k = 0; k < n; k++)
                        emit_result((k == 0) ? CMD_STOP : CMD_NONE, 8'd0, ST_OK, 1'b1,
                                    buf_byte(h, k), k == n - 1, 1'b0);
                end
                head_idx = (head_idx + 1) % QUEUE_DEPTH;
                pos = '0;
                ph = PH_STOP_WAIT;
                n_completions++;
            end
            PH_STOP_WAIT: begin
                if (take_engine()) ph = PH_IDLE;
            end
            PH_RETRY: ph = PH_START;
            PH_FAIL: begin
                head_idx = (head_idx + 1) % QUEUE_DEPTH;
                pos = '0;
                retries = '0;
                ph = PH_IDLE;
                emit_result(CMD_NONE, 8'd0, ST_OK, 1'b0, 8'd0, 1'b1, 1'b1);
                n_failures++;
            end
            default: begin
                ph = (head_idx != tail_idx) ? PH_START : PH_IDLE;
            end
        endcase
    endfunction

    // Work out the results of one accepted word
    function automatic void predict_word(t_in w);
        int queued;
        queued = (tail_idx + QUEUE_DEPTH - head_idx) % QUEUE_DEPTH;
        case (w.func)
            FUNC_LOAD: begin
                if (w.byte_index < MAX_BYTES)
                    bytes_mem[tail_idx*MAX_BYTES + w.byte_index] = w.data_byte;
            end
            FUNC_COMMIT: begin
                // Full is checked before length
                if (queued >= QUEUE_DEPTH - 1) begin
                    emit_result(CMD_NONE, 8'd0, ST_FULL, 1'b0, 8'd0, 1'b0, 1'b0);
                    n_full++;
                end else if (w.byte_count > MAX_BYTES) begin
                    emit_result(CMD_NONE, 8'd0, ST_LONG, 1'b0, 8'd0, 1'b0, 1'b0);
                    n_long++;
                end else begin
                    addr_mem[tail_idx] = w.target_address;
                    rd_mem[tail_idx] = w.read_flag;
                    cnt_mem[tail_idx] = w.byte_count;
                    tail_idx = (tail_idx + 1) % QUEUE_DEPTH;
                    emit_result(CMD_NONE, 8'd0, ST_OK, 1'b0, 8'd0, 1'b0, 1'b0);
                end
            end
            FUNC_STEP: step_sequencer(w);
            default: ;
        endcase
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            n_errors++;
        end
    endfunction

    function automatic void check_result(t_out want, t_out got);
        check_field("command", want.command, got.command);
        check_field("tx_byte", want.tx_byte, got.tx_byte);
        check_field("status", want.status, got.status);
        check_field("done_valid", want.done_valid, got.done_valid);
        check_field("done_byte", want.done_byte, got.done_byte);
        check_field("done_last", want.done_last, got.done_last);
        check_field("failed", want.failed, got.failed);
    endfunction

    // Driver: one word at a time from stim_words, random gaps between words
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_gap = 0;
        end else if (i_valid && !o_stall) begin
            predict_word(i_word);
            n_accepted++;
            if (!quiet && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 19);
            if (send_gap == 0 && stim_words.size() > 0) begin
                i_word <= stim_words.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end else if (!i_valid) begin
            if (send_gap > 0) begin
                send_gap--;
            end else if (stim_words.size() > 0) begin
                i_word <= stim_words.pop_front();
                i_valid <= 1'b1;
            end
        end
    end

    // Receiver stall: long hold-off on request, otherwise random bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left = 0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            if (stall_left == 0 && !quiet && $urandom_range(0, 9) == 0)
                stall_left = $urandom_range(1, 19);
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Monitor and watchdog
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                n_results++;
                if (predicted_results.size() == 0) begin
                    $error("result word with nothing expected: command %0d", o_word.command);
                    n_errors++;
                end else begin
                    want = predicted_results.pop_front();
                    check_result(want, o_word);
                end
            end
            if ((o_valid && !i_stall) || (i_valid && !o_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_CYCLES) begin
                $display("i2c_master_transaction_sequencer test failed");
                $finish;
            end
        end
    end

    // Stimulus builders
    function automatic t_in random_word();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[$bits(t_in)-1:0];
    endfunction

    function automatic void push_word(t_in w);
        stim_words.push_back(w);
        n_queued++;
    endfunction

    function automatic void send_load(logic [3:0] idx, logic [7:0] data);
        t_in w;
        w = random_word();
        w.func = FUNC_LOAD;
        w.byte_index = idx;
        w.data_byte = data;
        push_word(w);
    endfunction

    function automatic void send_commit(logic [6:0] addr, logic rd, logic [4:0] cnt);
        t_in w;
        w = random_word();
        w.func = FUNC_COMMIT;
        w.target_address = addr;
        w.read_flag = rd;
        w.byte_count = cnt;
        push_word(w);
    endfunction

    function automatic void send_step(logic done, logic nk);
        t_in w;
        w = random_word();
        w.func = FUNC_STEP;
        w.engine_done = done;
        w.nack = nk;
        push_word(w);
    endfunction

    function automatic void send_noise();
        t_in w;
        w = random_word();
        w.func = FUNC_UNUSED;
        push_word(w);
    endfunction

    // Writes load every byte they will send (byte zero even for length zero)
    function automatic void send_transaction(logic rd, logic [4:0] cnt, int nack_odds);
        int nsteps;
        if (!rd && cnt <= MAX_BYTES)
            for (int i = 0; i < ((cnt == 0) ? 1 : cnt); i++) send_load(i, $urandom_range(0, 255));
        if ($urandom_range(0, 3) == 0)
            send_load($urandom_range(0, MAX_BYTES - 1), $urandom_range(0, 255));
        send_commit($urandom_range(0, 127), rd, cnt);
        nsteps = 2 * ((cnt > MAX_BYTES) ? 0 : cnt) + $urandom_range(6, 12);
        for (int i = 0; i < nsteps; i++) begin
            if ($urandom_range(0, 15) == 0) send_noise();
            send_step($urandom_range(0, 3) != 0, $urandom_range(0, nack_odds - 1) == 0);
        end
    endfunction

    // Mostly short transactions, a few full-size or oversized
    function automatic logic [4:0] pick_count();
        int r;
        r = $urandom_range(0, 15);
        if (r < 10) return $urandom_range(0, 3);
        if (r < 13) return $urandom_range(4, 15);
        if (r < 14) return MAX_BYTES;
        return $urandom_range(MAX_BYTES + 1, 31);
    endfunction

    function automatic void send_phase(int n_trans, int nack_odds);
        for (int i = 0; i < n_trans; i++) send_transaction($urandom_range(0, 1), pick_count(),
                                                           nack_odds);
    endfunction

    task automatic wait_accepted();
        while (n_accepted != n_queued) @(negedge i_clk);
    endtask

    // Finish the queued transactions with clean engine responses
    task automatic drain_sequencer();
        wait_accepted();
        while (ph != PH_IDLE || head_idx != tail_idx) begin
            send_step(1'b1, 1'b0);
            wait_accepted();
        end
    endtask

    task automatic settle_block();
        wait_accepted();
        while (predicted_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_retry_limit(logic [7:0] value);
        drain_sequencer();
        settle_block();
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_RETRY_LIMIT;
        pwdata <= {24'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        retry_lim = value;
    endtask

    initial begin
        logic [7:0] last_lim;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: byte and address extremes, oversize, unused code, zero lengths, one retry
        send_load(4'd0, 8'hFF);
        send_load(4'd15, 8'h00);
        send_commit(7'h7F, 1'b0, 5'd1);
        send_commit(7'h00, 1'b1, 5'd17);
        send_commit(7'h2A, 1'b0, 5'd31);
        send_noise();
        send_commit(7'h00, 1'b1, 5'd0);
        send_load(4'd0, 8'hA5);
        send_commit(7'h55, 1'b0, 5'd0);
        for (int i = 0; i < 12; i++) send_step(1'b1, i == 3);

        // Retry limit zero: every NACK fails the transaction
        set_retry_limit(8'd0);
        send_phase(4, 3);

        // Highest limit; receiver holds off while oversize commits pile up
        set_retry_limit(8'd255);
        hold_left = 80;
        for (int i = 0; i < 8; i++)
            send_commit($urandom_range(0, 127), $urandom_range(0, 1),
                        $urandom_range(MAX_BYTES + 1, 31));
        send_transaction(1'b1, MAX_BYTES, 8);
        send_phase(3, 8);

        // Limit one, no idling on either side, one full-length write
        set_retry_limit(8'd1);
        quiet = 1'b1;
        send_transaction(1'b0, MAX_BYTES, 4);
        wait_accepted();
        quiet = 1'b0;
        send_phase(3, 3);

        // Last part: fill the queue to full with no idling, then step a little
        last_lim = $urandom_range(2, 6);
        set_retry_limit(last_lim);
        quiet = 1'b1;
        for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            if ($urandom_range(0, 1) == 1) begin
                send_commit($urandom_range(0, 127), 1'b1, $urandom_range(0, MAX_BYTES));
            end else begin
                send_load(4'd0, $urandom_range(0, 255));
                send_load(4'd1, $urandom_range(0, 255));
                send_commit($urandom_range(0, 127), 1'b0, $urandom_range(0, 2));
            end
        end
        send_commit($urandom_range(0, 127), 1'b0, 5'd20);
        send_commit($urandom_range(0, 127), 1'b1, 5'd2);
        for (int i = 0; i < 12; i++) send_step($urandom_range(0, 3) != 0, $urandom_range(0, 3) == 0);

        settle_block();
        repeat (10) @(posedge i_clk);
        $display("Run: %0d words, %0d result words; %0d completions, %0d failures, %0d retries.",
                 n_accepted, n_results, n_completions, n_failures, n_retries);
        $display("Commits rejected: %0d queue full, %0d oversize; retry limits 16,0,255,1,%0d.",
                 n_full, n_long, last_lim);
        if (n_errors == 0 && predicted_results.size() == 0) begin
            $display("i2c_master_transaction_sequencer test passed");
        end else begin
            $display("i2c_master_transaction_sequencer test failed");
        end
        $finish;
    end

endmodule
